FILE: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle as its antecedent
`define BNMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that holds in the cycle after its antecedent
`define BNMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// types, widths and codes shared by the box suppression block
// ----------------------------------------------------------------------------
package bnms_pkg;

	localparam int MAX_BOXES  = 32;
	localparam int COORD_BITS = 12;
	localparam int SCORE_BITS = 16;
	localparam int THR_BITS   = 9;
	localparam int IDX_BITS   = $clog2(MAX_BOXES);
	localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
	localparam int BOX_BITS   = 4 * COORD_BITS + SCORE_BITS;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int INTER_BITS = 2 * COORD_BITS;
	localparam int AREA_BITS  = 2 * DIFF_BITS;
	localparam int UNI_BITS   = AREA_BITS + 1;
	localparam int PROD_BITS  = THR_BITS + UNI_BITS - 1;
	localparam int SCALE_BITS = INTER_BITS + 8;
	localparam int CMP_BITS   = (PROD_BITS > SCALE_BITS) ? PROD_BITS : SCALE_BITS;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(128);

	// register index as seen on paddr[2]
	localparam logic REG_IOU_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] bottom;
		logic [SCORE_BITS-1:0] score;
	} box_t;

	typedef struct packed {
		logic load;
		logic sel_start;
		logic supp_start;
		logic emit;
		logic take;
		logic a_diff;
		logic a_area;
		logic clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy;
		logic found;
		logic pending;
		logic out_busy;
	} ctrl_stat_t;

endpackage

FILE: hdl/bnms_ram.sv
// ----------------------------------------------------------------------------
// bnms_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module bnms_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/bnms_ctrl.sv
// ----------------------------------------------------------------------------
// bnms_ctrl
// sequencer for loading, selection rounds, suppression sweeps and output
// ----------------------------------------------------------------------------
module bnms_ctrl import bnms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       final_box,
	output logic       in_stall,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_SEL_GO    = 10'b0000000010,
		ST_SEL_WAIT  = 10'b0000000100,
		ST_EMIT      = 10'b0000001000,
		ST_TAKE      = 10'b0000010000,
		ST_A_DIFF    = 10'b0000100000,
		ST_A_AREA    = 10'b0001000000,
		ST_SUPP_GO   = 10'b0010000000,
		ST_SUPP_WAIT = 10'b0100000000,
		ST_FINISH    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && final_box) begin
					state_d = ST_SEL_GO;
				end
			end
			ST_SEL_GO: begin
				cmd.sel_start = 1'b1;
				state_d       = ST_SEL_WAIT;
			end
			ST_SEL_WAIT: begin
				if (!stat.busy) begin
					state_d = stat.pending ? ST_EMIT : ST_TAKE;
				end
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = stat.found ? ST_TAKE : ST_FINISH;
				end
			end
			ST_TAKE: begin
				cmd.take = 1'b1;
				state_d  = ST_A_DIFF;
			end
			ST_A_DIFF: begin
				cmd.a_diff = 1'b1;
				state_d    = ST_A_AREA;
			end
			ST_A_AREA: begin
				cmd.a_area = 1'b1;
				state_d    = ST_SUPP_GO;
			end
			ST_SUPP_GO: begin
				cmd.supp_start = 1'b1;
				state_d        = ST_SUPP_WAIT;
			end
			ST_SUPP_WAIT: begin
				if (!stat.busy) begin
					state_d = ST_SEL_GO;
				end
			end
			ST_FINISH: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/bnms_datapath.sv
// ----------------------------------------------------------------------------
// bnms_datapath
// box memories, sweep counter, rank selection, overlap pipeline and output
// ----------------------------------------------------------------------------
module bnms_datapath import bnms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_stat_t            stat,
	input  logic [THR_BITS-1:0]   thr,
	input  box_t                  in_box,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_BITS-1:0]   kept_index,
	output logic                  last_kept
);

	logic [CNT_BITS-1:0] count_q;
	logic                wr_en;
	box_t                rd_a, rd_b;
	logic [BOX_BITS-1:0] rd_a_raw, rd_b_raw;

	// sweep control
	logic                run_q, sel_mode_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IDX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;

	// visited or suppressed
	logic [MAX_BOXES-1:0] done_q;

	logic                  best_found_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic [SCORE_BITS-1:0] best_score_q;
	logic                  pending_q;
	logic [IDX_BITS-1:0]   pending_idx_q;

	// the visiting box
	box_t                        a_q;
	logic signed [DIFF_BITS-1:0] wa_q, ha_q;
	logic signed [AREA_BITS-1:0] area_a_q;

	// overlap pipeline payload
	logic [COORD_BITS-1:0]       iw_s2, ih_s2;
	logic signed [DIFF_BITS-1:0] wb_s2, hb_s2;
	logic [INTER_BITS-1:0]       inter_s3, inter_s4, inter_s5;
	logic signed [AREA_BITS-1:0] area_b_s3;
	logic [UNI_BITS-1:0]         uni_s4;
	logic                        uni_pos_s5;
	logic [PROD_BITS-1:0]        prod_s5;

	logic                  out_valid_q, last_q;
	logic [IDX_BITS-1:0]   kept_q;

	logic [COORD_BITS-1:0]       x0, x1, y0, y1;
	logic signed [DIFF_BITS-1:0] dx, dy;
	logic                        sel_hit, supp_hit;

	assign wr_en = cmd.load && (count_q < CNT_BITS'(MAX_BOXES));

	bnms_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_BITS-1:0]),
		.wdata (in_box),
		.raddr (best_idx_q),
		.rdata (rd_a_raw)
	);

	bnms_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_BITS-1:0]),
		.wdata (in_box),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (rd_b_raw)
	);

	assign rd_a = box_t'(rd_a_raw);
	assign rd_b = box_t'(rd_b_raw);

	// overlap extents against the visiting box
	always_comb begin
		x0 = (a_q.left > rd_b.left) ? a_q.left : rd_b.left;
		y0 = (a_q.top > rd_b.top) ? a_q.top : rd_b.top;
		x1 = (a_q.right < rd_b.right) ? a_q.right : rd_b.right;
		y1 = (a_q.bottom < rd_b.bottom) ? a_q.bottom : rd_b.bottom;
		dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
		dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
	end

	// scanning upwards, >= lets the higher index win a tie
	assign sel_hit = v_s1 && sel_mode_q && !done_q[idx_s1] &&
		(!best_found_q || (rd_b.score >= best_score_q));

	assign supp_hit = v_s5 && !sel_mode_q && uni_pos_s5 &&
		(CMP_BITS'({inter_s5, 8'b0}) > CMP_BITS'(prod_s5));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			run_q        <= 1'b0;
			sel_mode_q   <= 1'b0;
			cnt_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			done_q       <= '0;
			best_found_q <= 1'b0;
			pending_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_BITS'(1);
			end

			if (cmd.sel_start || cmd.supp_start) begin
				run_q      <= 1'b1;
				cnt_q      <= '0;
				sel_mode_q <= cmd.sel_start;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == count_q - CNT_BITS'(1)) begin
					run_q <= 1'b0;
				end
			end
			v_s1 <= run_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;

			if (cmd.sel_start) begin
				best_found_q <= 1'b0;
			end else if (sel_hit) begin
				best_found_q <= 1'b1;
			end

			if (cmd.clear) begin
				done_q    <= '0;
				pending_q <= 1'b0;
			end else begin
				if (cmd.take) begin
					done_q[best_idx_q] <= 1'b1;
					pending_q          <= 1'b1;
				end
				if (supp_hit) begin
					done_q[idx_s5] <= 1'b1;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_BITS-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;

		if (sel_hit) begin
			best_idx_q   <= idx_s1;
			best_score_q <= rd_b.score;
		end
		if (cmd.take) begin
			pending_idx_q <= best_idx_q;
		end
		if (cmd.a_diff) begin
			a_q  <= rd_a;
			wa_q <= $signed({1'b0, rd_a.right}) - $signed({1'b0, rd_a.left});
			ha_q <= $signed({1'b0, rd_a.bottom}) - $signed({1'b0, rd_a.top});
		end
		if (cmd.a_area) begin
			area_a_q <= wa_q * ha_q;
		end

		iw_s2 <= dx[DIFF_BITS-1] ? '0 : dx[COORD_BITS-1:0];
		ih_s2 <= dy[DIFF_BITS-1] ? '0 : dy[COORD_BITS-1:0];
		wb_s2 <= $signed({1'b0, rd_b.right}) - $signed({1'b0, rd_b.left});
		hb_s2 <= $signed({1'b0, rd_b.bottom}) - $signed({1'b0, rd_b.top});

		inter_s3  <= iw_s2 * ih_s2;
		area_b_s3 <= wb_s2 * hb_s2;

		uni_s4   <= {area_a_q[AREA_BITS-1], area_a_q} + {area_b_s3[AREA_BITS-1], area_b_s3}
			- {{(UNI_BITS-INTER_BITS){1'b0}}, inter_s3};
		inter_s4 <= inter_s3;

		uni_pos_s5 <= !uni_s4[UNI_BITS-1] && (uni_s4 != '0);
		prod_s5    <= thr * uni_s4[UNI_BITS-2:0];
		inter_s5   <= inter_s4;

		if (cmd.emit) begin
			kept_q <= pending_idx_q;
			last_q <= !best_found_q;
		end
	end

	assign stat.busy     = run_q || v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign stat.found    = best_found_q;
	assign stat.pending  = pending_q;
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign kept_index = kept_q;
	assign last_kept  = last_q;

endmodule

FILE: hdl/box_non_max_suppression.sv
// ----------------------------------------------------------------------------
// box_non_max_suppression
// greedy non-maximum suppression of one frame of boxes by IoU threshold
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       box_left/top/right/bottom, score, final_box
//  out      source     out_valid / out_stall     kept_index, last_kept
//  cfg      sink       apb psel/penable/pwrite   iou_threshold at byte address 0
//
//  boxes load at one transfer per cycle; a final box starts suppression
//  a round: selection sweep, emit, box fetch and suppression sweep
//  the input is stalled from the final box until the last result is queued
//  reset clears the controller, counts and flags; the box memories need none
//  a stalled result holds in the output register and pauses the next emit
// ----------------------------------------------------------------------------
module box_non_max_suppression import bnms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// box input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] box_left,
	input  logic [COORD_BITS-1:0] box_top,
	input  logic [COORD_BITS-1:0] box_right,
	input  logic [COORD_BITS-1:0] box_bottom,
	input  logic [SCORE_BITS-1:0] score,
	input  logic                  final_box,
	// kept index output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_BITS-1:0]   kept_index,
	output logic                  last_kept,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	ctrl_cmd_t           cmd;
	ctrl_stat_t          stat;
	box_t                in_box;
	logic [THR_BITS-1:0] thr_q;

	// threshold register, to be written by the user only between frames; the block has no guard for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_IOU_THRESHOLD)) begin
			thr_q <= pwdata[THR_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? {{(32-THR_BITS){1'b0}}, thr_q} : '0;

	assign in_box = '{left: box_left, top: box_top, right: box_right,
		bottom: box_bottom, score: score};

	// sequencer
	bnms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.final_box (final_box),
		.in_stall  (in_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and arithmetic
	bnms_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.thr        (thr_q),
		.in_box     (in_box),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kept_index (kept_index),
		.last_kept  (last_kept)
	);

endmodule

FILE: hdl/bnms_checker.sv
// ----------------------------------------------------------------------------
// bnms_checker
// port-level checks on framing and result transfers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnms_checker import bnms_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  final_box,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [IDX_BITS-1:0]   kept_index,
	input logic                  last_kept
);

	// a stalled result holds
	`BNMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kept_index) && $stable(last_kept), "stalled result changed")

	// input closes only after a final box transfer
	`BNMS_ASSERT_NOW(a_close_on_final, $rose(in_stall), $past(in_valid && final_box), "input stalled without a final box")

	// input reopens only once the last result of the frame is queued
	`BNMS_ASSERT_NOW(a_open_after_last, $fell(in_stall), $past(out_valid && last_kept), "frame ended without a last result")

endmodule

bind box_non_max_suppression bnms_checker u_bnms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.final_box  (final_box),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kept_index (kept_index),
	.last_kept  (last_kept)
);
